/* design/mpq_pkg.sv */
package mpq_pkg;

  localparam int DEF_ENTRIES = 64;
  localparam int DEF_LEVELS  = 8;

  localparam logic [1:0] ACT_ENQUEUE = 2'd0;
  localparam logic [1:0] ACT_SELECT  = 2'd1;
  localparam logic [1:0] ACT_REMOVE  = 2'd2;
  localparam logic [1:0] ACT_BAD     = 2'd3;

  localparam logic [1:0] RES_DONE   = 2'd0;
  localparam logic [1:0] RES_IDLE   = 2'd1;
  localparam logic [1:0] RES_REJECT = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] entry_id;
    logic [7:0] level_request;
  } req_item_t;

  typedef struct packed {
    logic [5:0] chosen_entry;
    logic [1:0] result_code;
    logic [2:0] applied_level;
  } rsp_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_DECODE,
    OP_ENQ,
    OP_SCAN,
    OP_POP_RD,
    OP_POP_WR,
    OP_REM_LVL,
    OP_REM_HEAD,
    OP_WALK,
    OP_UNLINK,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic   take;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_sel;
    logic is_enq;
    logic bad;
    logic rem_absent;
    logic scan_hit;
    logic scan_last;
    logic head_is_id;
    logic walk_end;
    logic walk_found;
    logic tail_is_id;
    logic out_free;
  } dp_sts_t;

endpackage

/* design/mpq_ctrl.sv */
module mpq_ctrl import mpq_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [11:0] {
    ST_CLEAR    = 12'b0000_0000_0001,
    ST_IDLE     = 12'b0000_0000_0010,
    ST_DECODE   = 12'b0000_0000_0100,
    ST_ENQ      = 12'b0000_0000_1000,
    ST_SCAN     = 12'b0000_0001_0000,
    ST_POP_RD   = 12'b0000_0010_0000,
    ST_POP_WR   = 12'b0000_0100_0000,
    ST_REM_LVL  = 12'b0000_1000_0000,
    ST_REM_HEAD = 12'b0001_0000_0000,
    ST_WALK     = 12'b0010_0000_0000,
    ST_UNLINK   = 12'b0100_0000_0000,
    ST_OUT      = 12'b1000_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.take   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        cmd.op = OP_DECODE;
        if (sts.is_sel) begin
          state_next = ST_SCAN;
        end else if (sts.bad) begin
          state_next = ST_OUT;
        end else if (sts.is_enq) begin
          state_next = ST_ENQ;
        end else begin
          state_next = ST_REM_LVL;
        end
      end
      ST_ENQ: begin
        cmd.op     = OP_ENQ;
        state_next = ST_OUT;
      end
      ST_SCAN: begin
        cmd.op = OP_SCAN;
        if (sts.scan_hit) begin
          state_next = ST_POP_RD;
        end else if (sts.scan_last) begin
          state_next = ST_OUT;
        end
      end
      ST_POP_RD: begin
        cmd.op     = OP_POP_RD;
        state_next = ST_POP_WR;
      end
      ST_POP_WR: begin
        cmd.op     = OP_POP_WR;
        state_next = ST_OUT;
      end
      ST_REM_LVL: begin
        cmd.op     = OP_REM_LVL;
        state_next = sts.rem_absent ? ST_OUT : ST_REM_HEAD;
      end
      ST_REM_HEAD: begin
        cmd.op     = OP_REM_HEAD;
        state_next = sts.head_is_id ? ST_POP_WR : ST_WALK;
      end
      ST_WALK: begin
        cmd.op = OP_WALK;
        if (sts.walk_end) begin
          state_next = ST_OUT;
        end else if (sts.walk_found) begin
          state_next = sts.tail_is_id ? ST_OUT : ST_UNLINK;
        end
      end
      ST_UNLINK: begin
        cmd.op     = OP_UNLINK;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        cmd.op = OP_EMIT;
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

endmodule

/* design/mpq_datapath.sv */
module mpq_datapath import mpq_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int LEVELS  = DEF_LEVELS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  req_item_t req,
  input  logic      rsp_stall,
  output logic      rsp_valid,
  output rsp_item_t rsp,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts
);

  localparam int EW = $clog2(ENTRIES);
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [EW-1:0] LAST_ENTRY = EW'(ENTRIES - 1);
  localparam logic [LW-1:0] LAST_LEVEL = LW'(LEVELS - 1);

  // info word: {queued mark, level}
  logic [EW-1:0] link_mem [ENTRIES];
  logic [LW:0]   info_mem [ENTRIES];
  logic [EW-1:0] head_mem [LEVELS];
  logic [EW-1:0] tail_mem [LEVELS];
  logic [CW-1:0] cnt_mem  [LEVELS];

  logic [EW-1:0] link_q;
  logic [LW:0]   info_q;
  logic [EW-1:0] head_q;
  logic [EW-1:0] tail_q;
  logic [CW-1:0] cnt_q;

  req_item_t     item_q;
  rsp_item_t     res;
  logic [LEVELS-1:0] nonempty;
  logic [EW-1:0] clr_idx;
  logic [LW-1:0] wlvl;
  logic [EW-1:0] cur;
  logic [CW-1:0] steps;

  logic [EW-1:0] id_ix;
  logic [LW-1:0] clamp_lvl;
  logic [LW-1:0] info_lvl;
  logic          id_oob;
  logic          enq_ok;
  logic          walk_tail;

  logic          info_we;
  logic [EW-1:0] info_waddr;
  logic [LW:0]   info_wdata;
  logic          link_rd;
  logic [EW-1:0] link_raddr;
  logic          link_we;
  logic [EW-1:0] link_waddr;
  logic [EW-1:0] link_wdata;
  logic          lvl_rd;
  logic [LW-1:0] lvl_raddr;
  logic          lvl_we;
  logic [EW-1:0] head_wdata;
  logic [EW-1:0] tail_wdata;
  logic [CW-1:0] cnt_wdata;

  assign id_ix     = EW'(item_q.entry_id);
  assign id_oob    = 32'(item_q.entry_id) >= 32'(ENTRIES);
  assign clamp_lvl = (item_q.level_request >= 8'(LEVELS)) ? LAST_LEVEL
                                                           : LW'(item_q.level_request);
  assign info_lvl  = info_q[LW-1:0];
  assign enq_ok    = !info_q[LW];

  always_comb begin
    sts.clr_last   = clr_idx == LAST_ENTRY;
    sts.is_sel     = item_q.action == ACT_SELECT;
    sts.is_enq     = item_q.action == ACT_ENQUEUE;
    sts.bad        = (item_q.action == ACT_BAD) || id_oob;
    sts.rem_absent = !info_q[LW] || !nonempty[info_lvl];
    sts.scan_hit   = nonempty[wlvl];
    sts.scan_last  = wlvl == LAST_LEVEL;
    sts.head_is_id = head_q == id_ix;
    sts.walk_end   = steps >= cnt_q;
    sts.walk_found = link_q == id_ix;
    sts.tail_is_id = tail_q == id_ix;
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

  assign walk_tail = !sts.walk_end && sts.walk_found && sts.tail_is_id;

  always_comb begin
    info_we    = 1'b0;
    info_waddr = id_ix;
    info_wdata = '0;
    link_rd    = 1'b0;
    link_raddr = head_q;
    link_we    = 1'b0;
    link_waddr = tail_q;
    link_wdata = id_ix;
    lvl_rd     = 1'b0;
    lvl_raddr  = wlvl;
    lvl_we     = 1'b0;
    head_wdata = head_q;
    tail_wdata = tail_q;
    cnt_wdata  = cnt_q - CW'(1);
    unique case (cmd.op)
      OP_CLEAR: begin
        info_we    = 1'b1;
        info_waddr = clr_idx;
      end
      OP_DECODE: begin
        lvl_rd    = 1'b1;
        lvl_raddr = clamp_lvl;
      end
      OP_ENQ: begin
        if (enq_ok) begin
          info_we    = 1'b1;
          info_wdata = {1'b1, wlvl};
          link_we    = nonempty[wlvl];
          lvl_we     = 1'b1;
          tail_wdata = id_ix;
          if (nonempty[wlvl]) begin
            cnt_wdata = cnt_q + CW'(1);
          end else begin
            head_wdata = id_ix;
            cnt_wdata  = CW'(1);
          end
        end
      end
      OP_SCAN: begin
        lvl_rd = 1'b1;
      end
      OP_POP_RD: begin
        link_rd = 1'b1;
      end
      OP_POP_WR: begin
        info_we    = 1'b1;
        info_waddr = head_q;
        lvl_we     = 1'b1;
        head_wdata = (cnt_q > CW'(1)) ? link_q : head_q;
      end
      OP_REM_LVL: begin
        lvl_rd    = 1'b1;
        lvl_raddr = info_lvl;
      end
      OP_REM_HEAD: begin
        link_rd = 1'b1;
      end
      OP_WALK: begin
        if (walk_tail) begin
          info_we    = 1'b1;
          lvl_we     = 1'b1;
          tail_wdata = cur;
        end else if (!sts.walk_end) begin
          link_rd    = 1'b1;
          link_raddr = sts.walk_found ? id_ix : link_q;
        end
      end
      OP_UNLINK: begin
        info_we    = 1'b1;
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_q;
        lvl_we     = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (info_we) info_mem[info_waddr] <= info_wdata;
    if (cmd.op == OP_DECODE) info_q <= info_mem[id_ix];
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_waddr] <= link_wdata;
    if (link_rd) link_q <= link_mem[link_raddr];
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      head_mem[wlvl] <= head_wdata;
      tail_mem[wlvl] <= tail_wdata;
      cnt_mem[wlvl]  <= cnt_wdata;
    end
    if (lvl_rd) begin
      head_q <= head_mem[lvl_raddr];
      tail_q <= tail_mem[lvl_raddr];
      cnt_q  <= cnt_mem[lvl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty  <= '0;
      clr_idx   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLEAR) clr_idx <= clr_idx + EW'(1);
      if (cmd.op == OP_ENQ && enq_ok) nonempty[wlvl] <= 1'b1;
      if (cmd.op == OP_POP_WR && cnt_q == CW'(1)) nonempty[wlvl] <= 1'b0;
      if (cmd.op == OP_EMIT && sts.out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && req_valid) item_q <= req;
    if (cmd.op == OP_EMIT && sts.out_free) rsp <= res;
    unique case (cmd.op)
      OP_DECODE: begin
        res  <= '{chosen_entry: '0, result_code: RES_REJECT, applied_level: '0};
        wlvl <= sts.is_sel ? '0 : clamp_lvl;
      end
      OP_ENQ: begin
        if (enq_ok) begin
          res <= '{chosen_entry: '0, result_code: RES_DONE, applied_level: 3'(wlvl)};
        end
      end
      OP_SCAN: begin
        if (!sts.scan_hit) begin
          if (sts.scan_last) begin
            res <= '{chosen_entry: '0, result_code: RES_IDLE, applied_level: '0};
          end else begin
            wlvl <= wlvl + LW'(1);
          end
        end
      end
      OP_POP_WR: begin
        if (sts.is_sel) begin
          res <= '{chosen_entry: 6'(head_q), result_code: RES_DONE,
                   applied_level: 3'(wlvl)};
        end else begin
          res <= '{chosen_entry: '0, result_code: RES_DONE, applied_level: '0};
        end
      end
      OP_REM_LVL: begin
        wlvl <= info_lvl;
      end
      OP_REM_HEAD: begin
        cur   <= head_q;
        steps <= CW'(1);
      end
      OP_WALK: begin
        if (walk_tail) begin
          res <= '{chosen_entry: '0, result_code: RES_DONE, applied_level: '0};
        end else if (!sts.walk_end && !sts.walk_found) begin
          cur   <= link_q;
          steps <= steps + CW'(1);
        end
      end
      OP_UNLINK: begin
        res <= '{chosen_entry: '0, result_code: RES_DONE, applied_level: '0};
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/multilevel_priority_ready_queue_unit.sv */
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_item_t  (action, entry, level)
// rsp       out        rsp_valid / rsp_stall  rsp_item_t  (entry, code, level)
//
// One item at a time, from accept to result. Duplicate enqueue, absent remove, a bad
// action and entries beyond the table are rejected. Select scans the levels from 0 upward
// to the first non-empty one, or answers idle when all are empty. Remove walks its entry's
// level's list from the head; one link read a cycle.
// After reset a clearing pass over every entry empties the entry table;
// req_stall is high meanwhile. A stalled result holds in the output register.
module multilevel_priority_ready_queue_unit import mpq_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  parameter int LEVELS  = DEF_LEVELS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign req_stall = !cmd.take;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpq_datapath #(
    .ENTRIES (ENTRIES),
    .LEVELS  (LEVELS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule
